@@ src/assert_macros.svh @@
// Assertion macros used by the allocator unit RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ src/toa_pkg.sv @@
// Types and constants for the thruster on-time allocator.
// No dependencies.
package toa_pkg;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned INDEX_REACH = 16;

  localparam logic [1:0] CFG_NUM_THR = 2'd0;
  localparam logic [1:0] CFG_NOMINAL = 2'd1;
  localparam logic [1:0] CFG_MIN_ON = 2'd2;
  localparam logic [1:0] CFG_MAX_CMD = 2'd3;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_LOAD  = 9'b000000010,
    ST_MRD   = 9'b000000100,
    ST_MUL   = 9'b000001000,
    ST_ACC   = 9'b000010000,
    ST_FIN   = 9'b000100000,
    ST_RNK   = 9'b001000000,
    ST_EMIT  = 9'b010000000,
    ST_WAIT  = 9'b100000000
  } state_t;
endpackage

@@ src/toa_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module toa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/thruster_on_time_allocator_unit.sv @@
// Thruster on-time allocator: map RAM, on-time RAM and the sequencer.
// Depends on toa_pkg, toa_ram and assert_macros.svh.
// A load writes the three map elements of one row. A request computes one
// dot product per thruster (3 products each through one multiplier, then a
// finish step), then per thruster ranks it with one on-time RAM read per
// cycle and emits its command, holding it while out_stall is high.
// One item at a time. Reset is synchronous, active low, and restores the
// register defaults; RAMs are not cleared.
`include "assert_macros.svh"
module thruster_on_time_allocator_unit #(
  parameter int MAX_THRUSTERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [3:0]  in_row_index,
  input  logic signed [31:0] in_value_x,
  input  logic signed [31:0] in_value_y,
  input  logic signed [31:0] in_value_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_thruster_index,
  output logic signed [31:0] out_on_time,
  output logic        out_last
);
  localparam int TW = $clog2(MAX_THRUSTERS);
  localparam int MAPD = 3 * MAX_THRUSTERS;
  localparam int MW = $clog2(MAPD);
  localparam int LIM = (MAX_THRUSTERS < toa_pkg::INDEX_REACH) ? MAX_THRUSTERS
                       : toa_pkg::INDEX_REACH;

  toa_pkg::state_t state_r, state_nxt;

  logic [4:0] num_thr_r;
  logic signed [31:0] nominal_r, min_on_r;
  logic [4:0] max_cmd_r;

  logic signed [31:0] tq_r [3];
  logic [5:0] n_r, cmds_r;
  logic [5:0] t_r;
  logic [5:0] j_r;
  logic [1:0] k_r;
  logic [5:0] rank_r;
  logic signed [31:0] v_r;
  logic signed [63:0] prod_r;
  logic signed [67:0] acc_r;
  logic signed [31:0] lrow_r [3];
  logic [TW-1:0] lrow_idx_r;
  logic [1:0] lk_r;
  logic ld_skip_r;
  logic rd_pend_r;

  logic [3:0] o_idx_r;
  logic signed [31:0] o_val_r;
  logic o_last_r;
  logic o_valid_r;

  // Map RAM ports
  logic map_we;
  logic [MW-1:0] map_waddr, map_raddr;
  logic [31:0] map_rdata;
  // On-time RAM ports
  logic ot_we;
  logic [TW-1:0] ot_waddr, ot_raddr;
  logic [31:0] ot_wdata, ot_rdata;

  toa_ram #(.WIDTH(32), .DEPTH(MAPD)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(lrow_r[lk_r]),
    .raddr(map_raddr), .rdata(map_rdata)
  );
  toa_ram #(.WIDTH(32), .DEPTH(MAX_THRUSTERS)) u_ot (
    .clk(clk), .we(ot_we), .waddr(ot_waddr), .wdata(ot_wdata),
    .raddr(ot_raddr), .rdata(ot_rdata)
  );

  assign in_stall = (state_r != toa_pkg::ST_IDLE);
  assign out_valid = o_valid_r;
  assign out_thruster_index = o_idx_r;
  assign out_on_time = o_val_r;
  assign out_last = o_last_r;

  logic in_acc, out_acc;
  assign in_acc = in_valid && !in_stall;
  assign out_acc = o_valid_r && !out_stall;

  // Dot-product finish: round half up, add nominal, saturate, threshold
  logic signed [67:0] rounded;
  logic signed [52:0] sum_w;
  logic signed [31:0] sat_v, fin_v;
  always_comb begin
    rounded = (acc_r + 68'sd32768) >>> 16;
    sum_w = 53'(rounded) + 53'(nominal_r);
    if (sum_w > 53'sh7FFFFFFF) begin
      sat_v = 32'sh7FFFFFFF;
    end else if (sum_w < -53'sh80000000) begin
      sat_v = -32'sh80000000;
    end else begin
      sat_v = sum_w[31:0];
    end
    fin_v = (sat_v < min_on_r) ? 32'sd0 : sat_v;
  end

  // Map address of element k of thruster t
  logic [7:0] map_addr_w;
  assign map_addr_w = 8'(t_r) * 8'd3 + 8'(k_r);
  logic [7:0] map_waddr_w;
  assign map_waddr_w = 8'(lrow_idx_r) * 8'd3 + 8'(lk_r);

  always_comb begin
    map_we = (state_r == toa_pkg::ST_LOAD) && !ld_skip_r;
    map_waddr = map_waddr_w[MW-1:0];
    map_raddr = map_addr_w[MW-1:0];
    ot_we = (state_r == toa_pkg::ST_FIN);
    ot_waddr = t_r[TW-1:0];
    ot_wdata = fin_v;
    // First ranking cycle reads the thruster's own on-time
    ot_raddr = ((state_r == toa_pkg::ST_RNK) && !rd_pend_r) ? t_r[TW-1:0]
                                                             : j_r[TW-1:0];
  end

  logic gt_w;
  assign gt_w = ($signed(ot_rdata) > v_r) ||
                (($signed(ot_rdata) == v_r) && ((j_r - 6'd1) < t_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      toa_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_action == toa_pkg::ACT_LOAD) begin
            state_nxt = toa_pkg::ST_LOAD;
          end else if (num_thr_r == 5'd0) begin
            state_nxt = toa_pkg::ST_IDLE;
          end else begin
            state_nxt = toa_pkg::ST_MRD;
          end
        end
      end
      toa_pkg::ST_LOAD: begin
        if (lk_r == 2'd2) state_nxt = toa_pkg::ST_IDLE;
      end
      toa_pkg::ST_MRD: state_nxt = toa_pkg::ST_MUL;
      toa_pkg::ST_MUL: state_nxt = toa_pkg::ST_ACC;
      toa_pkg::ST_ACC: begin
        state_nxt = (k_r == 2'd2) ? toa_pkg::ST_FIN : toa_pkg::ST_MRD;
      end
      toa_pkg::ST_FIN: begin
        state_nxt = (t_r + 6'd1 == n_r) ? toa_pkg::ST_RNK : toa_pkg::ST_MRD;
      end
      toa_pkg::ST_RNK: begin
        if (rd_pend_r && j_r == n_r) state_nxt = toa_pkg::ST_EMIT;
      end
      toa_pkg::ST_EMIT: state_nxt = toa_pkg::ST_WAIT;
      toa_pkg::ST_WAIT: begin
        if (out_acc) begin
          state_nxt = o_last_r ? toa_pkg::ST_IDLE : toa_pkg::ST_RNK;
        end
      end
      default: state_nxt = toa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= toa_pkg::ST_IDLE;
      num_thr_r <= 5'd1;
      nominal_r <= '0;
      min_on_r <= '0;
      max_cmd_r <= 5'd16;
      o_valid_r <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          toa_pkg::CFG_NUM_THR: num_thr_r <= cfg_data[4:0];
          toa_pkg::CFG_NOMINAL: nominal_r <= cfg_data;
          toa_pkg::CFG_MIN_ON: min_on_r <= cfg_data;
          toa_pkg::CFG_MAX_CMD: max_cmd_r <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (state_r == toa_pkg::ST_EMIT) begin
        o_valid_r <= 1'b1;
      end else if (out_acc) begin
        o_valid_r <= 1'b0;
      end
      if (state_r == toa_pkg::ST_RNK) begin
        rd_pend_r <= !(rd_pend_r && j_r == n_r);
      end else begin
        rd_pend_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      toa_pkg::ST_IDLE: begin
        lrow_r[0] <= in_value_x;
        lrow_r[1] <= in_value_y;
        lrow_r[2] <= in_value_z;
        tq_r[0] <= in_value_x;
        tq_r[1] <= in_value_y;
        tq_r[2] <= in_value_z;
        lrow_idx_r <= TW'(in_row_index);
        ld_skip_r <= (32'(in_row_index) >= 32'(MAX_THRUSTERS));
        lk_r <= 2'd0;
        k_r <= 2'd0;
        t_r <= '0;
        acc_r <= '0;
        if (32'(num_thr_r) > LIM) n_r <= 6'(LIM);
        else n_r <= 6'(num_thr_r);
      end
      toa_pkg::ST_LOAD: lk_r <= lk_r + 2'd1;
      toa_pkg::ST_MUL: prod_r <= $signed(map_rdata) * tq_r[k_r];
      toa_pkg::ST_ACC: begin
        acc_r <= acc_r + 68'(prod_r);
        if (k_r != 2'd2) k_r <= k_r + 2'd1;
        if (6'(max_cmd_r) > n_r) cmds_r <= n_r;
        else cmds_r <= 6'(max_cmd_r);
      end
      toa_pkg::ST_FIN: begin
        k_r <= 2'd0;
        acc_r <= '0;
        if (t_r + 6'd1 == n_r) begin
          t_r <= '0;
          j_r <= '0;
          rank_r <= '0;
        end else begin
          t_r <= t_r + 6'd1;
        end
      end
      toa_pkg::ST_RNK: begin
        // First ranking cycle fetches own value, then one compare per entry
        if (!rd_pend_r) begin
          j_r <= '0;
        end else if (j_r == 6'd0) begin
          v_r <= $signed(ot_rdata);
          j_r <= 6'd1;
        end else begin
          if (gt_w) rank_r <= rank_r + 6'd1;
          if (j_r != n_r) j_r <= j_r + 6'd1;
        end
      end
      toa_pkg::ST_EMIT: begin
        o_idx_r <= t_r[3:0];
        o_val_r <= (rank_r < cmds_r) ? v_r : 32'sd0;
        o_last_r <= (t_r + 6'd1 == n_r);
      end
      toa_pkg::ST_WAIT: begin
        if (out_acc) begin
          t_r <= t_r + 6'd1;
          j_r <= '0;
          rank_r <= '0;
        end
      end
      default: ;
    endcase
  end

  `ASSERT_IMPL(a_no_in_busy, clk, rst_n, o_valid_r, in_stall, "input taken during output")
  `ASSERT_IMPL(a_idx_range, clk, rst_n, o_valid_r, (6'(o_idx_r) < n_r), "thruster index out of range")
  `ASSERT_NEXT(a_last_idle, clk, rst_n, out_acc && o_last_r, state_r == toa_pkg::ST_IDLE, "not idle after last")
endmodule

@@ test/tb_thruster_on_time_allocator_unit.sv @@
// Testbench for thruster_on_time_allocator_unit: loads the thruster map,
// sends torque requests under several register settings and checks every
// command against a built-in predictor. Depends on toa_pkg and the RTL.
`timescale 1ns / 100ps
module tb_thruster_on_time_allocator_unit;

  localparam int THR_MAX = 16;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 40;

  typedef struct {
    logic                               action;
    logic [toa_pkg::IDX_W-1:0]          row;
    logic signed [toa_pkg::VAL_W-1:0]   vx;
    logic signed [toa_pkg::VAL_W-1:0]   vy;
    logic signed [toa_pkg::VAL_W-1:0]   vz;
  } torque_item_t;

  typedef struct {
    logic [toa_pkg::IDX_W-1:0]        idx;
    logic signed [toa_pkg::VAL_W-1:0] on_time;
    logic                             last;
  } command_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall, in_action;
  logic [3:0] in_row_index;
  logic signed [31:0] in_value_x, in_value_y, in_value_z;
  logic out_valid, out_stall, out_last;
  logic [3:0] out_thruster_index;
  logic signed [31:0] out_on_time;

  thruster_on_time_allocator_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_row_index(in_row_index), .in_value_x(in_value_x),
    .in_value_y(in_value_y), .in_value_z(in_value_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_thruster_index(out_thruster_index), .out_on_time(out_on_time),
    .out_last(out_last)
  );

  // predictor copy of registers and map
  logic [4:0] num_thr_q;
  logic signed [31:0] nominal_q, min_on_q;
  logic [4:0] max_cmd_q;
  logic signed [31:0] map_x [THR_MAX];
  logic signed [31:0] map_y [THR_MAX];
  logic signed [31:0] map_z [THR_MAX];

  torque_item_t pending_items[$];
  command_t expected_cmds[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  bit hold_go = 0, hold_done = 0;
  int hold_left = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2, 3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      4: return $signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("ERROR t=%0t %s: got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // work out the commands of one accepted item, or update the map copy for a load
  task automatic allocate_on_times(torque_item_t it);
    logic signed [31:0] ot [THR_MAX];
    logic signed [67:0] acc;
    logic signed [67:0] rnd;
    longint v;
    int n, cmds, rank;
    command_t c;
    if (it.action == toa_pkg::ACT_LOAD) begin
      map_x[it.row] = it.vx;
      map_y[it.row] = it.vy;
      map_z[it.row] = it.vz;
      return;
    end
    n = (num_thr_q > THR_MAX) ? THR_MAX : num_thr_q;
    cmds = (max_cmd_q > n) ? n : max_cmd_q;
    for (int i = 0; i < n; i++) begin
      acc = map_x[i] * it.vx + map_y[i] * it.vy + map_z[i] * it.vz;
      rnd = (acc + 68'sd32768) >>> 16;
      v = rnd[63:0];
      v = v + nominal_q;
      if (v > 64'sh7fffffff) v = 64'sh7fffffff;
      if (v < -64'sh80000000) v = -64'sh80000000;
      if (v < min_on_q) v = 0;
      ot[i] = v[31:0];
    end
    for (int i = 0; i < n; i++) begin
      rank = 0;
      for (int j = 0; j < n; j++)
        if (ot[j] > ot[i] || (ot[j] == ot[i] && j < i)) rank++;
      c.idx = i[3:0];
      c.on_time = (rank < cmds) ? ot[i] : 32'sd0;
      c.last = (i + 1 == n);
      expected_cmds.push_back(c);
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_action <= toa_pkg::ACT_LOAD;
      in_row_index <= '0;
      in_value_x <= '0;
      in_value_y <= '0;
      in_value_z <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        torque_item_t acc_it;
        acc_it.action = in_action;
        acc_it.row = in_row_index;
        acc_it.vx = in_value_x;
        acc_it.vy = in_value_y;
        acc_it.vz = in_value_z;
        allocate_on_times(acc_it);
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          torque_item_t nx;
          nx = pending_items.pop_front();
          in_action <= nx.action;
          in_row_index <= nx.row;
          in_value_x <= nx.vx;
          in_value_y <= nx.vy;
          in_value_z <= nx.vz;
          in_valid <= 1'b1;
          tx_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_cmds.size() == 0) begin
          report("unexpected command, index", longint'(out_thruster_index), -1);
        end else begin
          command_t e;
          e = expected_cmds.pop_front();
          if (out_thruster_index !== e.idx)
            report("thruster_index", longint'(out_thruster_index), longint'(e.idx));
          if (out_on_time !== e.on_time)
            report($sformatf("on_time of thruster %0d", e.idx),
                   longint'(out_on_time), longint'(e.on_time));
          if (out_last !== e.last)
            report($sformatf("last of thruster %0d", e.idx),
                   longint'(out_last), longint'(e.last));
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        rx_gap <= pick_gap();
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      hold_left <= 1500;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic set_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      toa_pkg::CFG_NUM_THR: num_thr_q = data[4:0];
      toa_pkg::CFG_NOMINAL: nominal_q = data;
      toa_pkg::CFG_MIN_ON:  min_on_q = data;
      toa_pkg::CFG_MAX_CMD: max_cmd_q = data[4:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(logic [4:0] nt, logic [31:0] nom, logic [31:0] mn, logic [4:0] mc);
    set_reg(toa_pkg::CFG_NUM_THR, {27'd0, nt});
    set_reg(toa_pkg::CFG_NOMINAL, nom);
    set_reg(toa_pkg::CFG_MIN_ON, mn);
    set_reg(toa_pkg::CFG_MAX_CMD, {27'd0, mc});
  endtask

  task automatic push_item(logic act, logic [3:0] row, logic signed [31:0] x,
                           logic signed [31:0] y, logic signed [31:0] z);
    torque_item_t it;
    it.action = act;
    it.row = row;
    it.vx = x;
    it.vy = y;
    it.vz = z;
    pending_items.push_back(it);
  endtask

  // hold until every item is accepted and every command has come back
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_cmds.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int nreq;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = toa_pkg::CFG_NUM_THR;
    cfg_data = 0;
    num_thr_q = 1;
    nominal_q = 0;
    min_on_q = 0;
    max_cmd_q = 16;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full map with extreme and tied rows
    set_all(5'd16, 32'sd0, 32'sh80000000, 5'd16);
    push_item(toa_pkg::ACT_LOAD, 4'd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    push_item(toa_pkg::ACT_LOAD, 4'd1, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    push_item(toa_pkg::ACT_LOAD, 4'd2, 32'sh00010000, -32'sh00008000, 32'sh00000001);
    push_item(toa_pkg::ACT_LOAD, 4'd3, 32'sh00010000, -32'sh00008000, 32'sh00000001);
    for (int r = 4; r < THR_MAX; r++)
      push_item(toa_pkg::ACT_LOAD, r[3:0], rand_val(), rand_val(), rand_val());
    push_item(toa_pkg::ACT_REQUEST, 4'hf, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    push_item(toa_pkg::ACT_REQUEST, 4'h0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    push_item(toa_pkg::ACT_REQUEST, 4'h5, 32'sh00008000, 32'sh00000000, -32'sh00000001);
    push_item(toa_pkg::ACT_REQUEST, 4'ha, 32'sd0, 32'sd0, 32'sd0);
    drain();

    // directed: threshold, few commands, ties at zero, then zero, 31 and one thruster
    set_all(5'd16, 32'sh00020000, 32'sh00030000, 5'd3);
    push_item(toa_pkg::ACT_REQUEST, 4'h0, 32'sh00010000, 32'sh00020000, 32'sh00000000);
    push_item(toa_pkg::ACT_REQUEST, 4'h0, 32'sd0, 32'sd0, 32'sd0);
    drain();
    set_all(5'd0, 32'sh7fffffff, 32'sh7fffffff, 5'd0);
    push_item(toa_pkg::ACT_REQUEST, 4'h0, 32'sh00010000, 32'sh00010000, 32'sh00010000);
    push_item(toa_pkg::ACT_LOAD, 4'd5, rand_val(), rand_val(), rand_val());
    drain();
    set_all(5'd31, 32'sh80000000, 32'sh80000000, 5'd31);
    push_item(toa_pkg::ACT_REQUEST, 4'h0, rand_val(), rand_val(), rand_val());
    drain();
    set_all(5'd1, 32'sh7fffffff, 32'sh7fffffff, 5'd0);
    push_item(toa_pkg::ACT_REQUEST, 4'h0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    drain();

    // random phases
    for (int ph = 0; ph < 10; ph++) begin
      quiet = (ph % 4 == 3);
      case ($urandom_range(0, 3))
        0: set_all(5'd16, 32'sh7fffffff, 32'sh80000000, 5'd16);
        1: set_all(5'($urandom_range(0, 31)), rand_val(), rand_val(),
                   5'($urandom_range(0, 31)));
        default: set_all(5'($urandom_range(1, 16)), rand_val() >>> $urandom_range(0, 16),
                         $urandom_range(0, 1) ? 32'sh80000000 : rand_val() >>> 8,
                         5'($urandom_range(0, 16)));
      endcase
      if (ph == 4) hold_go = 1'b1;
      nreq = 7;
      while (nreq > 0) begin
        if ($urandom_range(0, 99) < 25) begin
          push_item(toa_pkg::ACT_LOAD, 4'($urandom_range(0, 15)),
                    rand_val(), rand_val(), rand_val());
        end else begin
          push_item(toa_pkg::ACT_REQUEST, 4'($urandom), rand_val(), rand_val(), rand_val());
          nreq--;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ thruster_on_time_allocator_unit.f @@
+incdir+src
src/toa_pkg.sv
src/toa_ram.sv
src/thruster_on_time_allocator_unit.sv
test/tb_thruster_on_time_allocator_unit.sv
